>>> design/multi_motor_state_feedback_core_defines.svh
// Assertion helpers for the state feedback core.
`ifndef MULTI_MOTOR_STATE_FEEDBACK_CORE_DEFINES_SVH
`define MULTI_MOTOR_STATE_FEEDBACK_CORE_DEFINES_SVH

// Same-cycle implication.
`define MMSF_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mmsf: same-cycle check failed");

// Next-cycle implication.
`define MMSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mmsf: next-cycle check failed");

`endif

>>> design/mmsf_pkg.sv
package mmsf_pkg;

   localparam int NUM_MOTORS_DEF = 8;
   localparam int STATE_LEN_DEF  = 3;

   localparam int CMD_W   = 2;
   localparam int IDX_W   = 3;
   localparam int SLOT_W  = 2;
   localparam int DATA_W  = 32;
   localparam int LEVEL_W = 16;
   localparam int DRIVE_W = 16;
   localparam int TYPE_W  = 4;

   localparam int ERR_W     = DATA_W + 1;
   localparam int PROD_W    = DATA_W + ERR_W;
   localparam int ACC_W     = PROD_W + 2;
   localparam int OUT_SHIFT = 17;

   localparam logic [CMD_W-1:0] CMD_STEP = 2'd0;
   localparam logic [CMD_W-1:0] CMD_GAIN = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TYPE = 2'd2;

   localparam logic [TYPE_W-1:0] TYPE_POWER = 4'd2;
   localparam logic [TYPE_W-1:0] TYPE_YAW   = 4'd6;

   localparam logic [LEVEL_W-1:0] BUF_LIMIT    = 16'd15360;
   localparam logic [LEVEL_W-1:0] BUF_CRITICAL = 16'd7680;

   localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 16'sh7FFF;
   localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = 16'sh8000;
   localparam logic signed [DRIVE_W-1:0] YAW_LIMIT = 16'sd21299;
   localparam logic signed [DRIVE_W-1:0] YAW_NEG   = -16'sd21299;

   localparam logic signed [DATA_W-1:0] VEL_ANOMALY = 32'sd524288000;

   // ratio scaling: x / 15360 = (x >> 10) / 15, the /15 by reciprocal
   localparam int RATIO_EXC_W      = 14;
   localparam int RATIO_PROD_W     = DRIVE_W + RATIO_EXC_W + 1;
   localparam int RATIO_FRAC_SHIFT = 10;
   localparam int RATIO_X_W        = 18;
   localparam int RECIP15_W        = 19;
   localparam int RECIP15_SHIFT    = 22;
   localparam logic [RECIP15_W-1:0] RECIP15 = 19'd279621;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic [IDX_W-1:0]         motor_index;
      logic [SLOT_W-1:0]        gain_slot;
      logic signed [DATA_W-1:0] write_value;
      logic signed [DATA_W-1:0] ref_position;
      logic signed [DATA_W-1:0] ref_velocity;
      logic signed [DATA_W-1:0] ref_third;
      logic signed [DATA_W-1:0] fb_position;
      logic signed [DATA_W-1:0] fb_velocity;
      logic signed [DATA_W-1:0] fb_third;
      logic [LEVEL_W-1:0]       power_buffer_level;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]          out_motor;
      logic signed [DRIVE_W-1:0] drive;
      logic                      anomaly;
      logic                      held;
   } rsp_type;

   typedef struct packed {
      logic [TYPE_W-1:0]         ctl_type;
      logic signed [DRIVE_W-1:0] drive;
   } motor_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TYPE,
      ST_BORROW,
      ST_MAC,
      ST_SAT,
      ST_POST,
      ST_SCALE
   } fsm_state_type;

endpackage

>>> design/mmsf_ratio.sv
module mmsf_ratio (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   input  logic signed [mmsf_pkg::DRIVE_W-1:0]         in_drive,
   input  logic [mmsf_pkg::LEVEL_W-1:0]                in_level,
   output logic                                        out_valid,
   output logic signed [mmsf_pkg::DRIVE_W-1:0]         out_drive
);

   localparam int QF_W = mmsf_pkg::RATIO_X_W + mmsf_pkg::RECIP15_W;

   logic [mmsf_pkg::LEVEL_W-1:0]              excess_full;
   logic [mmsf_pkg::RATIO_EXC_W-1:0]          excess;
   logic signed [mmsf_pkg::RATIO_PROD_W-1:0]  prod_in;
   logic signed [mmsf_pkg::RATIO_PROD_W-1:0]  prod_ff;
   logic                                      neg;
   logic [mmsf_pkg::RATIO_PROD_W-1:0]         mag;
   logic [mmsf_pkg::RATIO_X_W-1:0]            xq;
   logic [QF_W-1:0]                           qfull;
   logic [mmsf_pkg::DRIVE_W-1:0]              quot;
   logic signed [mmsf_pkg::DRIVE_W-1:0]       res_in;
   logic signed [mmsf_pkg::DRIVE_W-1:0]       res_ff;
   logic                                      v1_ff;
   logic                                      v2_ff;

   // level is known to lie above the critical level and below the limit
   assign excess_full = in_level - mmsf_pkg::BUF_CRITICAL;
   assign excess      = excess_full[mmsf_pkg::RATIO_EXC_W-1:0];
   assign prod_in     = mmsf_pkg::RATIO_PROD_W'(in_drive) *
                        mmsf_pkg::RATIO_PROD_W'($signed({1'b0, excess}));

   assign neg   = prod_ff[mmsf_pkg::RATIO_PROD_W-1];
   assign mag   = neg ? $unsigned(-prod_ff) : $unsigned(prod_ff);
   assign xq    = mmsf_pkg::RATIO_X_W'(mag >> mmsf_pkg::RATIO_FRAC_SHIFT);
   assign qfull = QF_W'(xq) * QF_W'(mmsf_pkg::RECIP15);
   assign quot  = mmsf_pkg::DRIVE_W'(qfull >> mmsf_pkg::RECIP15_SHIFT);
   assign res_in = neg ? -$signed(quot) : $signed(quot);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_drive = res_ff;

endmodule

>>> design/multi_motor_state_feedback_core.sv
// Per-motor saturated state feedback core.
// Input channel: req_item is taken at a clock edge with start high and busy low.
// Commands: step a motor, write one gain, or write a motor's control type.
// Writes finish in the accepting cycle; busy never rises and no result follows.
// A step gives one result beat: rsp_strobe is high for exactly one cycle with
// rsp_item valid. The receiver cannot stall; every beat must be taken.
// Step sequence: type read, a borrow state when the type is borrowed from a
// coupled motor, multiply-accumulate, saturate, post, and a scale state for
// power-ratio scaling. A held drive (unknown type) returns from the type or
// borrow state. The result beat shows in the first cycle with busy low; a new
// item may be taken in that same cycle. One item is in flight at a time.
// The rate is set by the single shared gain multiplier, fed one gain per cycle
// from the registered gain memory, then a saturate and a post stage.
// Reset (synchronous) clears all gains, types and stored drives through
// per-entry valid bits and returns the sequencer to idle at once.
`include "multi_motor_state_feedback_core_defines.svh"

module multi_motor_state_feedback_core #(
   parameter int NUM_MOTORS = mmsf_pkg::NUM_MOTORS_DEF,
   parameter int STATE_LEN  = mmsf_pkg::STATE_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mmsf_pkg::req_type req_item,
   output logic              rsp_strobe,
   output mmsf_pkg::rsp_type rsp_item
);

   localparam int MOT_W   = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
   localparam int GDEPTH  = NUM_MOTORS * STATE_LEN;
   localparam int GADDR_W = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
   localparam int CNT_W   = $clog2(STATE_LEN + 2);

   localparam logic [CNT_W-1:0] CNT_MUL_LAST  = CNT_W'(STATE_LEN);
   localparam logic [CNT_W-1:0] CNT_LAST      = CNT_W'(STATE_LEN + 1);
   localparam logic [CNT_W-1:0] CNT_ACC_FIRST = CNT_W'(2);

   mmsf_pkg::fsm_state_type state_ff, state_in;

   mmsf_pkg::req_type req_ff;
   logic [MOT_W-1:0]   in_mot;
   logic [MOT_W-1:0]   mot_ff;
   logic               item_ok;
   logic               accept;
   logic               go_step;
   logic               wr_gain;
   logic               wr_type;

   logic signed [mmsf_pkg::DATA_W-1:0] gain_mem [GDEPTH];
   logic [GDEPTH-1:0]                  gain_vld_ff;
   logic signed [mmsf_pkg::DATA_W-1:0] gain_q_ff;
   logic                               gv_q_ff;
   logic [GADDR_W-1:0]                 gbase_in;
   logic [GADDR_W-1:0]                 gbase_ff;
   logic [GADDR_W-1:0]                 gwaddr;
   logic [GADDR_W-1:0]                 graddr;
   logic signed [mmsf_pkg::DATA_W-1:0] gain_val;

   mmsf_pkg::motor_entry_type mot_mem [NUM_MOTORS];
   mmsf_pkg::motor_entry_type mot_q_ff;
   mmsf_pkg::motor_entry_type mot_wdata;
   logic [NUM_MOTORS-1:0]     type_vld_ff;
   logic [NUM_MOTORS-1:0]     drive_vld_ff;
   logic                      tv_q_ff;
   logic                      dv_q_ff;
   logic [MOT_W-1:0]          mot_raddr;
   logic [MOT_W-1:0]          mot_waddr;
   logic                      mot_we;

   logic [mmsf_pkg::TYPE_W-1:0]         own_now;
   logic signed [mmsf_pkg::DRIVE_W-1:0] own_drive_now;
   logic [mmsf_pkg::TYPE_W-1:0]         coup;
   logic                                coup_ok;
   logic [mmsf_pkg::TYPE_W-1:0]         bt;
   logic [mmsf_pkg::TYPE_W-1:0]         own_type_ff;
   logic signed [mmsf_pkg::DRIVE_W-1:0] own_drive_ff;
   logic [mmsf_pkg::TYPE_W-1:0]         eff_type_ff;

   logic signed [mmsf_pkg::ERR_W-1:0]  err_pos_ff;
   logic signed [mmsf_pkg::ERR_W-1:0]  err_vel_ff;
   logic signed [mmsf_pkg::ERR_W-1:0]  err_thd_ff;
   logic signed [mmsf_pkg::ERR_W-1:0]  err_sel;
   logic [CNT_W-1:0]                   cnt_ff;
   logic [CNT_W-1:0]                   cnt_dec;
   logic [mmsf_pkg::SLOT_W-1:0]        mul_idx;
   logic                               mul_en;
   logic                               acc_en;
   logic signed [mmsf_pkg::PROD_W-1:0] prod_in;
   logic signed [mmsf_pkg::PROD_W-1:0] prod_ff;
   logic signed [mmsf_pkg::ACC_W-1:0]  acc_ff;
   logic signed [mmsf_pkg::ACC_W-1:0]  acc_sh;
   logic signed [mmsf_pkg::DRIVE_W-1:0] sat_val;
   logic signed [mmsf_pkg::DRIVE_W-1:0] d_ff;
   logic signed [mmsf_pkg::DRIVE_W-1:0] yaw_d;
   logic                                vel_bad;
   logic                                is_power;
   logic                                starve;

   logic                                ratio_go;
   logic                                ratio_valid;
   logic signed [mmsf_pkg::DRIVE_W-1:0] ratio_drive;

   logic                                emit;
   logic                                wb;
   logic signed [mmsf_pkg::DRIVE_W-1:0] e_drive;
   logic                                e_anom;
   logic                                e_held;

   logic              rsp_strobe_ff;
   mmsf_pkg::rsp_type rsp_ff;

   // ---------------- accept and command decode ----------------
   assign busy    = (state_ff != mmsf_pkg::ST_IDLE);
   assign accept  = start && !busy;
   assign in_mot  = MOT_W'(req_item.motor_index);
   assign mot_ff  = MOT_W'(req_ff.motor_index);
   assign item_ok = (32'(req_item.motor_index) < NUM_MOTORS);
   assign go_step = accept && item_ok && (req_item.cmd == mmsf_pkg::CMD_STEP);
   assign wr_type = accept && item_ok && (req_item.cmd == mmsf_pkg::CMD_TYPE);
   assign wr_gain = accept && item_ok && (req_item.cmd == mmsf_pkg::CMD_GAIN) &&
                    (32'(req_item.gain_slot) < STATE_LEN);

   assign gbase_in = GADDR_W'(in_mot) * GADDR_W'(STATE_LEN);
   assign gwaddr   = gbase_in + GADDR_W'(req_item.gain_slot);
   assign graddr   = gbase_ff + GADDR_W'(cnt_ff);

   // ---------------- gain memory ----------------
   always_ff @(posedge clock) begin
      if (wr_gain) begin
         gain_mem[gwaddr] <= req_item.write_value;
      end
      gain_q_ff <= gain_mem[graddr];
      gv_q_ff   <= gain_vld_ff[graddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_vld_ff <= '0;
      end else if (wr_gain) begin
         gain_vld_ff[gwaddr] <= 1'b1;
      end
   end

   assign gain_val = gv_q_ff ? gain_q_ff : '0;

   // ---------------- motor memory: type and last drive ----------------
   assign own_now       = tv_q_ff ? mot_q_ff.ctl_type : '0;
   assign own_drive_now = dv_q_ff ? mot_q_ff.drive : '0;
   assign coup          = -own_now;
   assign coup_ok       = own_now[mmsf_pkg::TYPE_W-1] && (32'(coup) < NUM_MOTORS);
   assign bt            = own_now;

   assign mot_raddr = (state_ff == mmsf_pkg::ST_IDLE) ? in_mot :
                      (state_ff == mmsf_pkg::ST_TYPE) ? MOT_W'(coup) : mot_ff;
   assign mot_we    = wr_type || wb;
   assign mot_waddr = wr_type ? in_mot : mot_ff;
   assign mot_wdata = wr_type ?
      mmsf_pkg::motor_entry_type'{ctl_type: req_item.write_value[mmsf_pkg::TYPE_W-1:0],
                                  drive: '0} :
      mmsf_pkg::motor_entry_type'{ctl_type: own_type_ff, drive: e_drive};

   always_ff @(posedge clock) begin
      if (mot_we) begin
         mot_mem[mot_waddr] <= mot_wdata;
      end
      mot_q_ff <= mot_mem[mot_raddr];
      tv_q_ff  <= type_vld_ff[mot_raddr];
      dv_q_ff  <= drive_vld_ff[mot_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_vld_ff  <= '0;
         drive_vld_ff <= '0;
      end else begin
         if (mot_we) begin
            type_vld_ff[mot_waddr]  <= 1'b1;
            drive_vld_ff[mot_waddr] <= 1'b1;
         end
         if (wr_gain) begin
            drive_vld_ff[in_mot] <= 1'b0;
         end
      end
   end

   // ---------------- multiply-accumulate ----------------
   assign cnt_dec = cnt_ff - CNT_W'(1);
   assign mul_idx = mmsf_pkg::SLOT_W'(cnt_dec);

   always_comb begin
      unique case (mul_idx)
         2'd0:    err_sel = err_pos_ff;
         2'd1:    err_sel = err_vel_ff;
         2'd2:    err_sel = err_thd_ff;
         default: err_sel = '0;
      endcase
   end

   assign prod_in = mmsf_pkg::PROD_W'(gain_val) * mmsf_pkg::PROD_W'(err_sel);
   assign acc_sh  = acc_ff >>> mmsf_pkg::OUT_SHIFT;

   always_comb begin
      priority if (acc_sh > mmsf_pkg::ACC_W'(mmsf_pkg::DRIVE_MAX)) begin
         sat_val = mmsf_pkg::DRIVE_MAX;
      end else if (acc_sh < mmsf_pkg::ACC_W'(mmsf_pkg::DRIVE_MIN)) begin
         sat_val = mmsf_pkg::DRIVE_MIN;
      end else begin
         sat_val = mmsf_pkg::DRIVE_W'(acc_sh);
      end
   end

   // ---------------- post processing ----------------
   always_comb begin
      priority if (d_ff > mmsf_pkg::YAW_LIMIT) begin
         yaw_d = mmsf_pkg::YAW_LIMIT;
      end else if (d_ff < mmsf_pkg::YAW_NEG) begin
         yaw_d = mmsf_pkg::YAW_NEG;
      end else begin
         yaw_d = d_ff;
      end
   end

   assign vel_bad  = (req_ff.fb_velocity > mmsf_pkg::VEL_ANOMALY);
   assign is_power = (eff_type_ff == mmsf_pkg::TYPE_POWER) &&
                     (req_ff.power_buffer_level < mmsf_pkg::BUF_LIMIT);
   assign starve   = (req_ff.power_buffer_level <= mmsf_pkg::BUF_CRITICAL);

   mmsf_ratio u_ratio (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ratio_go),
      .in_drive  (d_ff),
      .in_level  (req_ff.power_buffer_level),
      .out_valid (ratio_valid),
      .out_drive (ratio_drive)
   );

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mmsf_pkg::ST_IDLE: begin
            if (go_step) state_in = mmsf_pkg::ST_TYPE;
         end
         mmsf_pkg::ST_TYPE: begin
            if (own_now[mmsf_pkg::TYPE_W-1]) begin
               state_in = coup_ok ? mmsf_pkg::ST_BORROW : mmsf_pkg::ST_IDLE;
            end else begin
               state_in = mmsf_pkg::ST_MAC;
            end
         end
         mmsf_pkg::ST_BORROW: begin
            state_in = bt[mmsf_pkg::TYPE_W-1] ? mmsf_pkg::ST_IDLE : mmsf_pkg::ST_MAC;
         end
         mmsf_pkg::ST_MAC: begin
            if (cnt_ff == CNT_LAST) state_in = mmsf_pkg::ST_SAT;
         end
         mmsf_pkg::ST_SAT: begin
            state_in = mmsf_pkg::ST_POST;
         end
         mmsf_pkg::ST_POST: begin
            state_in = (is_power && !starve) ? mmsf_pkg::ST_SCALE : mmsf_pkg::ST_IDLE;
         end
         mmsf_pkg::ST_SCALE: begin
            if (ratio_valid) state_in = mmsf_pkg::ST_IDLE;
         end
         default: begin
            state_in = mmsf_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      emit     = 1'b0;
      wb       = 1'b0;
      e_drive  = d_ff;
      e_anom   = 1'b0;
      e_held   = 1'b0;
      ratio_go = 1'b0;
      mul_en   = 1'b0;
      acc_en   = 1'b0;
      unique case (state_ff)
         mmsf_pkg::ST_TYPE: begin
            if (own_now[mmsf_pkg::TYPE_W-1] && !coup_ok) begin
               emit    = 1'b1;
               e_held  = 1'b1;
               e_drive = own_drive_now;
            end
         end
         mmsf_pkg::ST_BORROW: begin
            if (bt[mmsf_pkg::TYPE_W-1]) begin
               emit    = 1'b1;
               e_held  = 1'b1;
               e_drive = own_drive_ff;
            end
         end
         mmsf_pkg::ST_MAC: begin
            mul_en = (cnt_ff != '0) && (cnt_ff <= CNT_MUL_LAST);
            acc_en = (cnt_ff >= CNT_ACC_FIRST);
         end
         mmsf_pkg::ST_POST: begin
            priority if (is_power) begin
               if (starve) begin
                  emit    = 1'b1;
                  wb      = 1'b1;
                  e_drive = '0;
               end else begin
                  ratio_go = 1'b1;
               end
            end else if (eff_type_ff == mmsf_pkg::TYPE_YAW) begin
               emit    = 1'b1;
               wb      = 1'b1;
               e_anom  = vel_bad;
               e_drive = vel_bad ? '0 : yaw_d;
            end else begin
               emit = 1'b1;
               wb   = 1'b1;
            end
         end
         mmsf_pkg::ST_SCALE: begin
            if (ratio_valid) begin
               emit    = 1'b1;
               wb      = 1'b1;
               e_drive = ratio_drive;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mmsf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------- datapath registers ----------------
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff     <= req_item;
         gbase_ff   <= gbase_in;
         err_pos_ff <= mmsf_pkg::ERR_W'(req_item.ref_position) -
                       mmsf_pkg::ERR_W'(req_item.fb_position);
         err_vel_ff <= mmsf_pkg::ERR_W'(req_item.ref_velocity) -
                       mmsf_pkg::ERR_W'(req_item.fb_velocity);
         err_thd_ff <= mmsf_pkg::ERR_W'(req_item.ref_third) -
                       mmsf_pkg::ERR_W'(req_item.fb_third);
      end
      unique case (state_ff)
         mmsf_pkg::ST_TYPE: begin
            own_type_ff  <= own_now;
            own_drive_ff <= own_drive_now;
            eff_type_ff  <= own_now;
            cnt_ff       <= '0;
            acc_ff       <= '0;
         end
         mmsf_pkg::ST_BORROW: begin
            eff_type_ff <= bt;
            cnt_ff      <= '0;
            acc_ff      <= '0;
         end
         mmsf_pkg::ST_MAC: begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (mul_en) prod_ff <= prod_in;
            if (acc_en) acc_ff <= acc_ff + mmsf_pkg::ACC_W'(prod_ff);
         end
         mmsf_pkg::ST_SAT: begin
            d_ff <= sat_val;
         end
         default: begin
         end
      endcase
   end

   // ---------------- result beat ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff.out_motor <= req_ff.motor_index;
         rsp_ff.drive     <= e_drive;
         rsp_ff.anomaly   <= e_anom;
         rsp_ff.held      <= e_held;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // ---------------- checks ----------------
   `MMSF_ASSERT_HOLDS(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   `MMSF_ASSERT_HOLDS(a_anomaly_zero, clock, reset, rsp_strobe && rsp_item.anomaly, rsp_item.drive == '0 && !rsp_item.held)
   `MMSF_ASSERT_NEXT(a_step_busy, clock, reset, go_step, busy)
   `MMSF_ASSERT_HOLDS(a_cnt_bound, clock, reset, state_ff == mmsf_pkg::ST_MAC, cnt_ff <= CNT_LAST)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import mmsf_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_BEATS = 1100;
   localparam int PHASES       = 10;
   localparam logic [31:0] MAXW = 32'h7FFF_FFFF;
   localparam logic [31:0] MINW = 32'h8000_0000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   logic    rsp_strobe;
   req_type req_item;
   rsp_type rsp_item;

   int unsigned gap_max = 6;
   int          idle_cycles = 0;

   class drive_board;
      logic signed [DATA_W-1:0]  gains [NUM_MOTORS_DEF][STATE_LEN_DEF];
      logic signed [TYPE_W-1:0]  types [NUM_MOTORS_DEF];
      logic signed [DRIVE_W-1:0] last_drive [NUM_MOTORS_DEF];
      rsp_type                   pending_drives[$];
      int                        faults;

      function new();
         foreach (gains[i, j]) gains[i][j] = '0;
         foreach (types[i]) types[i] = '0;
         foreach (last_drive[i]) last_drive[i] = '0;
         faults = 0;
      endfunction

      function void note_item(req_type r);
         int               m;
         int               c;
         int               tv;
         int               d;
         longint           err [3];
         logic signed [67:0] acc;
         logic signed [67:0] g68;
         logic signed [67:0] e68;
         rsp_type          want;
         m = r.motor_index;
         case (r.cmd)
            CMD_GAIN: begin
               if (r.gain_slot < STATE_LEN_DEF) begin
                  gains[m][r.gain_slot] = r.write_value;
                  last_drive[m] = '0;
               end
            end
            CMD_TYPE: begin
               types[m] = r.write_value[TYPE_W-1:0];
               last_drive[m] = '0;
            end
            CMD_STEP: begin
               err[0] = longint'($signed(r.ref_position)) - longint'($signed(r.fb_position));
               err[1] = longint'($signed(r.ref_velocity)) - longint'($signed(r.fb_velocity));
               err[2] = longint'($signed(r.ref_third)) - longint'($signed(r.fb_third));
               tv = int'(types[m]);
               // negative type: borrow from the coupled motor, one level only
               if (tv < 0) begin
                  c = -tv;
                  tv = (c < NUM_MOTORS_DEF) ? int'(types[c]) : -1;
               end
               want = '0;
               want.out_motor = r.motor_index;
               if (tv < 0) begin
                  d = last_drive[m];
                  want.held = 1'b1;
               end else begin
                  acc = '0;
                  for (int i = 0; i < STATE_LEN_DEF; i++) begin
                     g68 = gains[m][i];
                     e68 = err[i];
                     acc += g68 * e68;
                  end
                  acc = acc >>> 17;
                  if (acc > 68'sd32767) d = 32767;
                  else if (acc < -68'sd32768) d = -32768;
                  else d = int'(acc);
                  if (tv == int'(TYPE_POWER) && r.power_buffer_level < BUF_LIMIT) begin
                     if (r.power_buffer_level <= BUF_CRITICAL) d = 0;
                     else d = int'(longint'(d) *
                                   longint'(r.power_buffer_level - BUF_CRITICAL) /
                                   longint'(BUF_LIMIT));
                  end else if (tv == int'(TYPE_YAW)) begin
                     if (d > YAW_LIMIT) d = YAW_LIMIT;
                     if (d < YAW_NEG) d = YAW_NEG;
                     if ($signed(r.fb_velocity) > VEL_ANOMALY) begin
                        d = 0;
                        want.anomaly = 1'b1;
                     end
                  end
                  last_drive[m] = 16'(d);
               end
               want.drive = 16'(d);
               pending_drives.push_back(want);
            end
            default: ;
         endcase
      endfunction

      function void check_drive(rsp_type got);
         rsp_type want;
         if (pending_drives.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("unexpected drive beat: motor %0d drive %0d anomaly %0b held %0b",
                        got.out_motor, got.drive, got.anomaly, got.held);
         end else begin
            want = pending_drives.pop_front();
            if (got.out_motor !== want.out_motor || got.drive !== want.drive ||
                got.anomaly !== want.anomaly || got.held !== want.held) begin
               faults++;
               if (faults <= 10)
                  $display("drive mismatch: got motor %0d drive %0d anomaly %0b held %0b, %s",
                           got.out_motor, got.drive, got.anomaly, got.held,
                           $sformatf("expected motor %0d drive %0d anomaly %0b held %0b",
                                     want.out_motor, want.drive, want.anomaly, want.held));
            end
         end
      endfunction
   endclass

   drive_board board = new();

   multi_motor_state_feedback_core DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) board.check_drive(rsp_item);
   end

   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   function automatic req_type write_beat(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] m,
                                          logic [SLOT_W-1:0] slot, logic [31:0] value);
      req_type r;
      r = '0;
      r.cmd = cmd;
      r.motor_index = m;
      r.gain_slot = slot;
      r.write_value = value;
      return r;
   endfunction

   function automatic req_type step_beat(logic [IDX_W-1:0] m, logic [31:0] rp, logic [31:0] rv,
                                         logic [31:0] rt, logic [31:0] fp, logic [31:0] fv,
                                         logic [31:0] ft, logic [LEVEL_W-1:0] lvl);
      req_type r;
      r = '0;
      r.cmd = CMD_STEP;
      r.motor_index = m;
      r.ref_position = rp;
      r.ref_velocity = rv;
      r.ref_third = rt;
      r.fb_position = fp;
      r.fb_velocity = fv;
      r.fb_third = ft;
      r.power_buffer_level = lvl;
      return r;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
         2: begin
            case ($urandom_range(0, 4))
               0: return MAXW;
               1: return MINW;
               2: return 32'h0;
               3: return 32'hFFFF_FFFF;
               default: return 32'h0001_0000;
            endcase
         end
         default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      endcase
   endfunction

   function automatic req_type random_beat();
      req_type     r;
      int unsigned sel;
      r.motor_index = $urandom;
      r.gain_slot = $urandom;
      r.write_value = $urandom;
      r.ref_position = $urandom;
      r.ref_velocity = $urandom;
      r.ref_third = $urandom;
      r.fb_position = $urandom;
      r.fb_velocity = $urandom;
      r.fb_third = $urandom;
      r.power_buffer_level = $urandom;
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
         r.cmd = CMD_UNUSED;
      end else if (sel < 63) begin
         r.cmd = CMD_STEP;
         r.ref_position = pick_word();
         r.ref_velocity = pick_word();
         r.ref_third = pick_word();
         r.fb_position = ($urandom_range(0, 2) != 0) ?
            r.ref_position - ($urandom_range(0, 32'h0002_0000) - 32'h0001_0000) : pick_word();
         r.fb_velocity = ($urandom_range(0, 2) != 0) ?
            r.ref_velocity - ($urandom_range(0, 32'h0002_0000) - 32'h0001_0000) : pick_word();
         r.fb_third = ($urandom_range(0, 2) != 0) ?
            r.ref_third - ($urandom_range(0, 32'h0002_0000) - 32'h0001_0000) : pick_word();
         if ($urandom_range(0, 4) == 0)
            r.fb_velocity = 32'(VEL_ANOMALY) + $urandom_range(0, 4) - 2;
         case ($urandom_range(0, 3))
            0: r.power_buffer_level = $urandom;
            1: r.power_buffer_level = $urandom_range(7000, 16000);
            2: r.power_buffer_level = BUF_CRITICAL + $urandom_range(0, 1);
            default: r.power_buffer_level = BUF_LIMIT - $urandom_range(0, 1);
         endcase
      end else if (sel < 85) begin
         r.cmd = CMD_GAIN;
         r.gain_slot = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
         case ($urandom_range(0, 3))
            0: r.write_value = $urandom;
            1: r.write_value = pick_word();
            default: r.write_value = $urandom_range(0, 32'h0001_0000) - 32'h0000_8000;
         endcase
      end else begin
         r.cmd = CMD_TYPE;
         case ($urandom_range(0, 5))
            0: r.write_value = $urandom;
            1: r.write_value = 32'(TYPE_POWER);
            2: r.write_value = 32'(TYPE_YAW);
            default: r.write_value = 32'($urandom_range(0, 15)) - 32'd8;
         endcase
      end
      return r;
   endfunction

   task automatic send_beat(input req_type beat);
      int unsigned gap;
      gap = $urandom_range(0, gap_max);
      repeat (gap) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start = 1'b1;
      req_item = beat;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      board.note_item(beat);
   endtask

   initial begin
      logic [LEVEL_W-1:0] levels [3] = '{16'd7680, 16'd7681, 16'd15360};
      req_type            beat;
      int                 sent;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // saturation both ways, ignored gain slot
      send_beat(write_beat(CMD_GAIN, 3'd0, 2'd0, MAXW));
      send_beat(write_beat(CMD_GAIN, 3'd0, 2'd1, MINW));
      send_beat(write_beat(CMD_GAIN, 3'd0, 2'd2, 32'h0001_0000));
      send_beat(write_beat(CMD_GAIN, 3'd0, 2'd3, 32'h1234_5678));
      send_beat(step_beat(3'd0, MAXW, MINW, MAXW, MINW, MAXW, MINW, 16'hFFFF));
      send_beat(step_beat(3'd0, MINW, MAXW, MINW, MAXW, MINW, MAXW, 16'h0000));
      // power ratio around its thresholds
      send_beat(write_beat(CMD_TYPE, 3'd1, 2'd0, 32'(TYPE_POWER)));
      send_beat(write_beat(CMD_GAIN, 3'd1, 2'd0, 32'h0001_0000));
      foreach (levels[i]) send_beat(step_beat(3'd1, 32'h8000, 0, 0, 0, 0, 0, levels[i]));
      // yaw limit and velocity anomaly
      send_beat(write_beat(CMD_TYPE, 3'd2, 2'd0, 32'(TYPE_YAW)));
      send_beat(write_beat(CMD_GAIN, 3'd2, 2'd1, 32'h0002_0000));
      send_beat(step_beat(3'd2, 0, 32'h0001_0000, 0, 0, 32'(VEL_ANOMALY), 0, 16'd0));
      send_beat(step_beat(3'd2, 0, MAXW, 0, 0, 32'h0, 0, 16'd0));
      send_beat(step_beat(3'd2, 0, MAXW, 0, 0, 32'(VEL_ANOMALY) + 1, 0, 16'd0));
      // borrowed types, out-of-range coupling, nested borrow, wide type value
      send_beat(write_beat(CMD_TYPE, 3'd3, 2'd0, 32'hFFFF_FFFE));
      send_beat(step_beat(3'd3, 0, 0, 0, 0, MAXW, 0, 16'd0));
      send_beat(write_beat(CMD_TYPE, 3'd5, 2'd0, 32'hFFFF_FFF8));
      send_beat(step_beat(3'd5, MAXW, 0, 0, 0, 0, 0, 16'd0));
      send_beat(write_beat(CMD_TYPE, 3'd4, 2'd0, 32'h7FFF_FFF9));
      send_beat(step_beat(3'd4, 0, 0, 0, 0, 0, 0, 16'd0));
      send_beat(write_beat(CMD_TYPE, 3'd7, 2'd0, 32'hFFFF_FFFD));
      send_beat(step_beat(3'd7, 0, 0, 0, 0, 0, 0, 16'd0));
      send_beat(write_beat(CMD_UNUSED, 3'd6, 2'd0, 32'h0));

      for (int p = 0; p < PHASES; p++) begin
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
         sent = 0;
         while (sent < RANDOM_BEATS / PHASES) begin
            beat = random_beat();
            send_beat(beat);
            if (beat.cmd != CMD_UNUSED) sent++;
         end
      end

      @(negedge clock);
      start = 1'b0;
      while (board.pending_drives.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (board.faults == 0 && board.pending_drives.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+design
design/mmsf_pkg.sv
design/mmsf_ratio.sv
design/multi_motor_state_feedback_core.sv
tb/tb_top.sv
